// ===== rtl/core/lruebds_pkg.sv =====
// Package with shared types, sizes and codes for the LRU eviction list.
`default_nettype none
package lruebds_pkg;

    localparam int ENTRIES = 64;
    localparam int IDW     = 6;
    localparam int SEQW    = 32;
    localparam int IW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TOUCH  = 2'd2,
        ACT_EVICT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NOOP = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    // Contents of one position in the recency order.
    typedef struct packed {
        logic            vld;
        logic [IDW-1:0]  id;
        logic [SEQW-1:0] seq;
        logic            dirty;
    } t_cell;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic shift_en;
        logic load;
        logic update;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/lruebds_cell.sv =====
// One position of the recency chain: holds an entry and shifts toward the old end.
`default_nettype none
module lruebds_cell
    import lruebds_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_cell_ctl      i_ctl,
    input  wire t_cell          i_up,
    input  wire t_cell          i_new,
    input  wire logic [IDW-1:0] i_key,
    input  wire logic           i_kill,
    input  wire logic           i_seen,
    output logic                o_seen,
    output logic                o_hit,
    output t_cell               o_q
);

    t_cell r_q;
    t_cell n_q;

    // The removal point and every position above it take the upper neighbor.
    assign o_seen = i_seen | i_kill;
    assign o_hit  = r_q.vld && (r_q.id == i_key);
    assign o_q    = r_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.load) begin
            n_q = i_new;
        end else if (i_ctl.shift_en && o_seen) begin
            n_q = i_up;
        end else if (i_ctl.update) begin
            n_q.seq   = i_new.seq;
            n_q.dirty = i_new.dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lru_evict_busy_dirty_skip.sv =====
// Top level of the LRU replacement list with dirty and busy skipping on eviction.
//
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+------------------------------
//  command  | i_action i_entry_id i_can_evict i_is_dirty   | word taken when start && !busy
//           | i_last_used_seq i_completed_seq              |
//  result   | o_status o_victim_id o_victim_valid          | o_done high for one cycle
//
// Insert, remove and touch complete in the cycle they are accepted and their result
// word is registered and appears in the next cycle; busy stays low, so such commands
// can be issued back to back. Evict walks the chain one position per cycle from the
// least-recent end and keeps busy high while it looks at each position, including
// the step that finds the scan has run off the end of the list. The result word is
// shown in the first cycle that busy is low again. Reset is synchronous and active
// low and empties the chain. The receiver cannot stall: each result word is shown
// exactly once.
//
// The recency order is kept as a row of cells, position 0 being the least recent.
// Listed entries are packed at the low positions, so the list length tells where
// the next entry goes. Unlinking an entry shifts every cell above it down by one.
`default_nettype none
module lru_evict_busy_dirty_skip
    import lruebds_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      i_action,
    input  wire logic [IDW-1:0]  i_entry_id,
    input  wire logic            i_can_evict,
    input  wire logic            i_is_dirty,
    input  wire logic [SEQW-1:0] i_last_used_seq,
    input  wire logic [SEQW-1:0] i_completed_seq,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [IDW-1:0]       o_victim_id,
    output logic                 o_victim_valid
);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [SEQW-1:0] r_completed;
    logic            r_done;
    logic [1:0]      r_status;
    logic [IDW-1:0]  r_victim;
    logic            r_vvalid;

    t_cell           cq   [ENTRIES];
    t_cell_ctl       ctl  [ENTRIES];
    logic            seen [ENTRIES+1];
    logic [ENTRIES-1:0] hit;
    logic [ENTRIES-1:0] kill;
    t_cell           new_cell;

    logic            acc;
    logic            in_range;
    logic            resident;
    logic            do_ins_new;
    logic            do_update;
    logic            do_remove;
    logic            do_touch;
    logic            scan_end;
    logic            scan_pass;
    logic            cur_busy;
    logic [SEQW-1:0] diff;
    t_cell           cur;

    assign busy     = (r_state == S_SCAN);
    assign acc      = start && !busy;
    assign in_range = (32'(i_entry_id) < 32'(ENTRIES));
    assign resident = |hit;

    assign new_cell = '{vld: 1'b1, id: i_entry_id, seq: i_last_used_seq, dirty: i_is_dirty};

    // Command decode for insert, remove and touch.
    always_comb begin
        do_ins_new = 1'b0;
        do_update  = 1'b0;
        do_remove  = 1'b0;
        do_touch   = 1'b0;
        if (acc && in_range) begin
            unique case (t_action'(i_action))
                ACT_INSERT: begin
                    do_ins_new = i_can_evict && !resident
                                 && (32'(r_count) < 32'(ENTRIES));
                    do_update  = i_can_evict && resident;
                end
                ACT_REMOVE: do_remove = resident;
                ACT_TOUCH:  do_touch  = resident;
                ACT_EVICT:  ;
                default:    ;
            endcase
        end
    end

    // Scan step: look at the cell under the scan index.
    assign scan_end  = busy && (r_idx >= r_count);
    assign cur       = cq[r_idx[IW-1:0]];
    assign diff      = r_completed - cur.seq;
    assign cur_busy  = diff[SEQW-1] && (cur.seq != '0);
    assign scan_pass = busy && !scan_end && !cur.dirty && !cur_busy;

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign kill[g] = ((do_remove || do_touch) && hit[g])
                         || (scan_pass && (r_idx[IW-1:0] == IW'(g)));
        assign ctl[g].shift_en = do_remove || do_touch || scan_pass;
        assign ctl[g].load     = (do_ins_new && (r_count == CW'(g)))
                                 || (do_touch && (r_count == CW'(g + 1)));
        assign ctl[g].update   = do_update && hit[g];

        lruebds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_up    ((g == ENTRIES - 1) ? t_cell'('0) : cq[(g + 1) % ENTRIES]),
            .i_new   (new_cell),
            .i_key   (i_entry_id),
            .i_kill  (kill[g]),
            .i_seen  (seen[g]),
            .o_seen  (seen[g+1]),
            .o_hit   (hit[g]),
            .o_q     (cq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (t_action'(i_action) == ACT_EVICT) begin
                        r_state     <= S_SCAN;
                        r_idx       <= '0;
                        r_completed <= i_completed_seq;
                    end else begin
                        r_done   <= 1'b1;
                        r_victim <= '0;
                        r_vvalid <= 1'b0;
                        r_status <= (do_ins_new || do_update || do_remove || do_touch)
                                    ? ST_DONE : ST_NOOP;
                        if (do_ins_new) begin
                            r_count <= r_count + 1'b1;
                        end else if (do_remove) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    r_status <= ST_NONE;
                    r_victim <= '0;
                    r_vvalid <= 1'b0;
                end else if (scan_pass) begin
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    r_status <= ST_DONE;
                    r_victim <= cur.id;
                    r_vvalid <= 1'b1;
                    r_count  <= r_count - 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: r_state <= S_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_victim_id    = r_victim;
    assign o_victim_valid = r_vvalid;

endmodule
`default_nettype wire

// ===== dv/lru_evict_busy_dirty_skip_tb.sv =====
// Self-checking testbench for the LRU replacement list with dirty and busy eviction skips.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the recency order the block should hold and queues the result words it predicts.
class lru_order_tracker;
    bit                               listed[lruebds_pkg::ENTRIES];
    bit [lruebds_pkg::SEQW-1:0]       use_seq[lruebds_pkg::ENTRIES];
    bit                               dirty_mark[lruebds_pkg::ENTRIES];
    // Index 0 is the least-recent entry.
    int                               order[$];
    bit [1:0]                         want_status[$];
    bit [lruebds_pkg::IDW-1:0]        want_victim[$];
    bit                               want_valid[$];
    int                               errors;

    function void drop_entry(int id);
        int k;
        for (k = 0; k < order.size(); k++) begin
            if (order[k] == id) begin
                order.delete(k);
                break;
            end
        end
        listed[id] = 0;
    endfunction

    // Records one accepted command word and predicts its result word.
    function void note_command(bit [1:0] act, bit [5:0] id, bit can_ev, bit dirty,
                               bit [31:0] seq, bit [31:0] done_seq);
        bit [1:0]  st;
        bit [5:0]  vic;
        bit        vv;
        bit [31:0] diff;
        int        k;
        int        x;
        st = lruebds_pkg::ST_NOOP;
        vic = '0;
        vv = 1'b0;
        case (act)
            lruebds_pkg::ACT_EVICT: begin
                st = lruebds_pkg::ST_NONE;
                for (k = 0; k < order.size(); k++) begin
                    x = order[k];
                    diff = done_seq - use_seq[x];
                    if (!dirty_mark[x] && !(diff[31] && use_seq[x] != 0)) begin
                        drop_entry(x);
                        st = lruebds_pkg::ST_DONE;
                        vic = 6'(x);
                        vv = 1'b1;
                        break;
                    end
                end
            end
            lruebds_pkg::ACT_INSERT: begin
                if (can_ev) begin
                    if (!listed[id]) begin
                        order.push_back(id);
                        listed[id] = 1;
                    end
                    use_seq[id] = seq;
                    dirty_mark[id] = dirty;
                    st = lruebds_pkg::ST_DONE;
                end
            end
            lruebds_pkg::ACT_REMOVE: begin
                if (listed[id]) begin
                    drop_entry(id);
                    st = lruebds_pkg::ST_DONE;
                end
            end
            default: begin
                if (listed[id]) begin
                    drop_entry(id);
                    order.push_back(id);
                    listed[id] = 1;
                    use_seq[id] = seq;
                    dirty_mark[id] = dirty;
                    st = lruebds_pkg::ST_DONE;
                end
            end
        endcase
        want_status.push_back(st);
        want_victim.push_back(vic);
        want_valid.push_back(vv);
    endfunction

    function void report(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endfunction

    // Compares one result word against the oldest prediction.
    function void check_result(bit [1:0] st, bit [5:0] vic, bit vv);
        if (want_status.size() == 0) begin
            report("result word with no command pending");
            return;
        end
        if (st != want_status[0])
            report($sformatf("status %0d, expected %0d", st, want_status[0]));
        if (vic != want_victim[0])
            report($sformatf("victim %0d, expected %0d", vic, want_victim[0]));
        if (vv != want_valid[0])
            report($sformatf("victim_valid %0d, expected %0d", vv, want_valid[0]));
        void'(want_status.pop_front());
        void'(want_victim.pop_front());
        void'(want_valid.pop_front());
    endfunction
endclass

module lru_evict_busy_dirty_skip_tb;
    import lruebds_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      i_action;
    logic [IDW-1:0]  i_entry_id;
    logic            i_can_evict;
    logic            i_is_dirty;
    logic [SEQW-1:0] i_last_used_seq;
    logic [SEQW-1:0] i_completed_seq;
    logic            o_done;
    logic [1:0]      o_status;
    logic [IDW-1:0]  o_victim_id;
    logic            o_victim_valid;

    lru_order_tracker tracker;
    int               burst_left;

    lru_evict_busy_dirty_skip u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_entry_id      (i_entry_id),
        .i_can_evict     (i_can_evict),
        .i_is_dirty      (i_is_dirty),
        .i_last_used_seq (i_last_used_seq),
        .i_completed_seq (i_completed_seq),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_victim_id     (o_victim_id),
        .o_victim_valid  (o_victim_valid)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Every result word is shown for one cycle and must be taken then; the tracker
    // compares it with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_result(o_status, o_victim_id, o_victim_valid);
    end

    // Sends one command word: raise start, hold it until an edge sees busy low,
    // then note the word as accepted. Between words of a burst start stays high,
    // so it is never lowered and raised in the same step. Most bursts are set apart by
    // a gap of random length.
    task automatic send_word(bit [1:0] act, bit [5:0] id, bit can_ev, bit dirty,
                             bit [31:0] seq, bit [31:0] done_seq);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start           <= 1'b1;
        i_action        <= act;
        i_entry_id      <= id;
        i_can_evict     <= can_ev;
        i_is_dirty      <= dirty;
        i_last_used_seq <= seq;
        i_completed_seq <= done_seq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_command(act, id, can_ev, dirty, seq, done_seq);
    endtask

    // Random sequence number, often small so that busy windows are crossed near zero.
    function automatic bit [31:0] pick_seq();
        case ($urandom_range(0, 5))
            0: pick_seq = 0;
            1: pick_seq = $urandom_range(0, 40);
            2: pick_seq = 32'h8000_0000 + $urandom_range(0, 40) - 20;
            3: pick_seq = 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: pick_seq = $urandom;
        endcase
    endfunction

    initial begin
        bit [1:0]  act;
        bit [5:0]  id;
        bit [31:0] seq;
        int        n;
        int        wait_cycles;
        tracker = new();
        burst_left = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_action        = ACT_INSERT;
        i_entry_id      = '0;
        i_can_evict     = 1'b0;
        i_is_dirty      = 1'b0;
        i_last_used_seq = '0;
        i_completed_seq = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-list evict, edge ids, non-evictable insert, re-insert,
        // touch and remove of unlisted entries, dirty and busy skips, seq zero never busy.
        send_word(ACT_EVICT, 6'd0, 1, 0, 0, 0);
        send_word(ACT_REMOVE, 6'd63, 1, 0, 0, 0);
        send_word(ACT_TOUCH, 6'd0, 1, 0, 0, 0);
        send_word(ACT_INSERT, 6'd5, 0, 0, 1, 0);
        send_word(ACT_INSERT, 6'd0, 1, 1, 32'hFFFF_FFFF, 0);
        send_word(ACT_INSERT, 6'd63, 1, 0, 32'd100, 0);
        send_word(ACT_INSERT, 6'd7, 1, 0, 32'd0, 0);
        send_word(ACT_INSERT, 6'd9, 1, 0, 32'h8000_0000, 0);
        send_word(ACT_INSERT, 6'd63, 0, 1, 32'd3, 0);
        send_word(ACT_EVICT, 6'd0, 0, 0, 0, 32'd50);
        send_word(ACT_EVICT, 6'd0, 0, 0, 0, 32'd50);
        send_word(ACT_INSERT, 6'd63, 1, 0, 32'd60, 0);
        send_word(ACT_EVICT, 6'd0, 0, 0, 0, 32'd50);
        send_word(ACT_TOUCH, 6'd0, 0, 0, 32'd1, 0);
        send_word(ACT_EVICT, 6'h3F, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_EVICT, 6'd0, 0, 0, 0, 32'h7FFF_FFFF);
        send_word(ACT_REMOVE, 6'd63, 0, 0, 0, 0);
        send_word(ACT_REMOVE, 6'd63, 0, 0, 0, 0);
        send_word(ACT_EVICT, 6'd0, 0, 0, 0, 0);

        // Random part: inserts dominate so the list fills and evicts scan deep.
        for (n = 0; n < 1300; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: act = ACT_INSERT;
                4:          act = ACT_REMOVE;
                5, 6:       act = ACT_TOUCH;
                default:    act = ACT_EVICT;
            endcase
            id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
            seq = pick_seq();
            send_word(act, id, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0,
                      seq, pick_seq());
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (tracker.want_status.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.want_status.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Slowest run: about 1320 words, each with its longest wait to be accepted plus the longest gap.
    initial begin
        #(12 * 400000);
        $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lruebds_pkg.sv
rtl/core/lruebds_cell.sv
rtl/core/lru_evict_busy_dirty_skip.sv
dv/lru_evict_busy_dirty_skip_tb.sv
